### hdl/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared constants, codes and types of the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

	// screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CELL_W     = 16;
	// cells moved up by one scroll (text rows below the top line)
	localparam int MOVED      = (ROWS - 3) * COLUMNS;

	localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] MOVED_LAST = ADDR_W'(MOVED - 1);
	localparam logic [ADDR_W-1:0] BLANK_LAST = ADDR_W'(MOVED + COLUMNS - 1);

	// command codes
	localparam logic [1:0] CMD_PUT    = 2'd0;
	localparam logic [1:0] CMD_SETPOS = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	// character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TOP   = 8'h7F;

	localparam logic [CELL_W-1:0] BLANK_CLEAR = 16'h0720;
	localparam logic [7:0]        ATTR_RESET  = 8'h07;

	// register index of the attribute register
	localparam logic REG_TEXT_ATTR = 1'b0;

	// beat widths
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;

	// controller states
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_EXEC   = 7'b0000010,
		ST_RDWAIT = 7'b0000100,
		ST_SCROLL = 7'b0001000,
		ST_BLANK  = 7'b0010000,
		ST_CLEAR  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	// screen store access from the controller
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

### hdl/text_mode_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer_top
// Text-mode console engine: screen store of 16-bit cells and a cursor,
// driven by put character, set position, clear and read cell commands.
//
//   channel  dir  handshake         content
//   s_*      in   tvalid/tready     one command beat
//   m_*      out  tvalid/tready     one result beat per command
//   apb      in   psel/penable      text attribute register at 0x0
//
// a character that scrolls walks the store
// clear walks every cell (one write port per cycle)
// after reset a clearing pass over every cell runs before s_tready rises
// a new command is taken while a result still waits on m_*
// ----------------------------------------------------------------------------
module text_mode_console_writer_top import tmcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// char_code[7:0], new_column[14:8], new_row[19:15], cell_index[30:20]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// command[1:0]
	input  logic [1:0]            s_tuser,
	// master side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// cursor_column[6:0], cursor_row[11:7], cursor_address[23:12],
	// read_data[39:24]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [7:0]        text_attribute;
	mem_req_t          mem_req;
	logic [CELL_W-1:0] mem_rdata;

	// configuration registers
	tmcw_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.text_attribute (text_attribute)
	);

	// command sequencer
	tmcw_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_attribute (text_attribute),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_cmd         (s_tuser),
		.in_data        (s_tdata),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_data       (m_tdata),
		.mem_req        (mem_req),
		.mem_rdata      (mem_rdata)
	);

	// screen store
	tmcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule

### hdl/tmcw_ram.sv
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/tmcw_regs.sv
// ----------------------------------------------------------------------------
// tmcw_regs
// Configuration register file behind the APB port (text attribute).
// ----------------------------------------------------------------------------
module tmcw_regs import tmcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  text_attribute
);

	logic [7:0] attr_q;
	logic       hit;

	assign pready = 1'b1;
	assign hit    = (paddr[2] == REG_TEXT_ATTR) && (paddr[1:0] == 2'd0);

	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			attr_q <= pwdata[7:0];
		end
	end

	// read back
	assign prdata         = hit ? {24'd0, attr_q} : 32'd0;
	assign text_attribute = attr_q;

endmodule

### hdl/tmcw_ctrl.sv
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Command sequencer: cursor, screen store read-modify-write, scroll and
// clear sweeps, and the result register.
// ----------------------------------------------------------------------------
module tmcw_ctrl import tmcw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            text_attribute,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            in_cmd,
	input  logic [IN_DATA_W-1:0]  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output mem_req_t              mem_req,
	input  logic [CELL_W-1:0]     mem_rdata
);

	state_t              state_q;
	logic [1:0]          cmd_q;
	logic [7:0]          ch_q;
	logic [6:0]          ncol_q;
	logic [4:0]          nrow_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [6:0]          col_q;
	logic [4:0]          row_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic                from_cmd_q;
	logic                oob_q;
	logic [CELL_W-1:0]   data_q;
	logic                mv_valid_s1;
	logic [ADDR_W-1:0]   mv_addr_s1;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [7:0]          put_col;
	logic [5:0]          put_row;
	logic                put_we;
	logic [6:0]          put_pos;
	logic [CELL_W-1:0]   put_cell;
	logic [ADDR_W-1:0]   put_addr;
	logic                put_scroll;
	logic [6:0]          clamp_col;
	logic [4:0]          clamp_row;
	logic [11:0]         cursor_addr;
	logic                out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// put character: new cursor and the cell to write
	always_comb begin
		put_col  = {1'b0, col_q};
		put_row  = {1'b0, row_q};
		put_we   = 1'b0;
		put_pos  = col_q;
		put_cell = {text_attribute, CH_SPACE};
		priority if (ch_q == CH_BS && col_q != 7'd0) begin
			put_col = {1'b0, col_q} - 8'd1;
			put_pos = col_q - 7'd1;
			put_we  = 1'b1;
		end else if (ch_q == CH_TAB) begin
			put_col = ({1'b0, col_q} + 8'd8) & 8'hF8;
		end else if (ch_q == CH_CR) begin
			put_col = 8'd0;
		end else if (ch_q == CH_LF) begin
			put_col = 8'd0;
			put_row = {1'b0, row_q} + 6'd1;
		end else if (ch_q >= CH_SPACE && ch_q <= CH_TOP) begin
			put_we   = 1'b1;
			put_cell = {text_attribute, ch_q};
			put_col  = {1'b0, col_q} + 8'd1;
		end else begin
			// ignored byte: cursor and store stay
			put_we = 1'b0;
		end
		// line wrap
		if (put_col >= 8'(COLUMNS)) begin
			put_col = 8'd0;
			put_row = put_row + 6'd1;
		end
	end

	assign put_scroll = (put_row >= 6'(ROWS - 2));
	assign put_addr   = ADDR_W'(12'(row_q) * 12'(COLUMNS) + 12'(put_pos));

	// set position clamps
	assign clamp_col = ({1'b0, ncol_q} >= 8'(COLUMNS)) ? 7'(COLUMNS - 1) : ncol_q;
	assign clamp_row = ({1'b0, nrow_q} >= 6'(ROWS)) ? 5'(ROWS - 1) : nrow_q;

	// hardware cursor address
	assign cursor_addr = (12'(row_q) + 12'd1) * 12'(COLUMNS) + 12'(col_q);

	// screen store port: a pending scroll move wins the write port
	always_comb begin
		mem_req = '0;
		if (state_q == ST_SCROLL) begin
			mem_req.raddr = ADDR_W'(12'(cnt_q) + 12'(COLUMNS));
		end else begin
			mem_req.raddr = idx_q;
		end
		if (mv_valid_s1) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = mv_addr_s1;
			mem_req.wdata = mem_rdata;
		end else if (state_q == ST_EXEC && cmd_q == CMD_PUT) begin
			mem_req.we    = put_we;
			mem_req.waddr = put_addr;
			mem_req.wdata = put_cell;
		end else if (state_q == ST_BLANK) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = cnt_q;
			mem_req.wdata = {text_attribute, CH_SPACE};
		end else if (state_q == ST_CLEAR) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = cnt_q;
			mem_req.wdata = BLANK_CLEAR;
		end
	end

	// scroll move pipeline: read row below, write it in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_valid_s1 <= 1'b0;
		end else begin
			mv_valid_s1 <= (state_q == ST_SCROLL);
		end
	end

	always_ff @(posedge clk) begin
		mv_addr_s1 <= cnt_q;
	end

	// input beat capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= in_cmd;
			ch_q   <= in_data[7:0];
			ncol_q <= in_data[14:8];
			nrow_q <= in_data[19:15];
			idx_q  <= in_data[30:20];
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			col_q       <= 7'd0;
			row_q       <= 5'd0;
			cnt_q       <= '0;
			from_cmd_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (cmd_q)
						CMD_PUT: begin
							col_q <= put_col[6:0];
							cnt_q <= '0;
							if (put_scroll) begin
								row_q   <= 5'(put_row - 6'd1);
								state_q <= ST_SCROLL;
							end else begin
								row_q   <= put_row[4:0];
								state_q <= ST_DONE;
							end
						end
						CMD_SETPOS: begin
							col_q   <= clamp_col;
							row_q   <= clamp_row;
							state_q <= ST_DONE;
						end
						CMD_CLEAR: begin
							col_q      <= 7'd0;
							row_q      <= 5'd0;
							cnt_q      <= '0;
							from_cmd_q <= 1'b1;
							state_q    <= ST_CLEAR;
						end
						CMD_READ: begin
							state_q <= ST_RDWAIT;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_RDWAIT: begin
					state_q <= ST_DONE;
				end
				ST_SCROLL: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == MOVED_LAST) begin
						state_q <= ST_BLANK;
					end
				end
				ST_BLANK: begin
					if (!mv_valid_s1) begin
						cnt_q <= cnt_q + ADDR_W'(1);
						if (cnt_q == BLANK_LAST) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == CELL_LAST) begin
						state_q <= from_cmd_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result beat valid: set when a result is loaded, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			data_q <= '0;
			oob_q  <= (12'(idx_q) >= 12'(CELL_COUNT));
		end else if (state_q == ST_RDWAIT) begin
			data_q <= oob_q ? '0 : mem_rdata;
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {data_q, cursor_addr, row_q, col_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives put character, set position, clear and read cell commands into the
// console writer, with random gaps on the command side and random stalls on
// the result side. A shadow screen and cursor kept here predict every result
// beat, which is compared field by field. The attribute register is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	import tmcw_pkg::*;

	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 100;
	localparam int WATCHDOG_LIMIT = 12000;
	localparam int PHASES         = 4;
	localparam int PHASE_ITEMS    = 150;
	localparam int TAIL_ITEMS     = 80;
	localparam int DIR_ROWS       = 25;

	localparam logic [2:0] ATTR_ADDR = 3'(4 * REG_TEXT_ATTR);

	// one result beat, packed as on m_tdata (cursor_column in the lowest bits)
	typedef struct packed {
		logic [15:0] read_data;
		logic [11:0] cursor_address;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_column;
	} result_t;

	// one row of the directed table
	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  ch;
		logic [6:0]  ncol;
		logic [4:0]  nrow;
		logic [10:0] idx;
		logic        fixed;
		result_t     want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = CMD_PUT;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [2:0]            paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// shadow of the block's state
	logic [15:0] screen_model [CELL_COUNT];
	int          cur_col;
	int          cur_row;
	logic [7:0]  text_attr;

	result_t pending_results [$];
	int      fail_count = 0;
	int      stuck_cycles = 0;
	int      stall_left = 0;
	bit      calm = 1'b0;
	bit      tail_part = 1'b0;

	text_mode_console_writer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// blank screen, cursor home
	function automatic void wipe_screen();
		for (int i = 0; i < CELL_COUNT; i++)
			screen_model[i] = BLANK_CLEAR;
		cur_col = 0;
		cur_row = 0;
	endfunction

	// apply one command to the shadow state and return the result beat
	function automatic result_t console_step(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [6:0] ncol, input logic [4:0] nrow, input logic [10:0] idx);
		result_t r;
		int      moved;
		r = '0;
		moved = (ROWS - 3) * COLUMNS;
		case (cmd)
			CMD_PUT: begin
				if (ch == CH_BS && cur_col != 0) begin
					cur_col--;
					screen_model[cur_row * COLUMNS + cur_col] = {text_attr, CH_SPACE};
				end else if (ch == CH_TAB) begin
					cur_col = (cur_col + 8) & ~7;
				end else if (ch == CH_CR) begin
					cur_col = 0;
				end else if (ch == CH_LF) begin
					cur_col = 0;
					cur_row++;
				end else if (ch >= CH_SPACE && ch <= CH_TOP) begin
					screen_model[cur_row * COLUMNS + cur_col] = {text_attr, ch};
					cur_col++;
				end
				// line wrap
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
				// scroll the text area once, the status rows stay put
				if (cur_row >= ROWS - 2) begin
					for (int i = 0; i < moved; i++)
						screen_model[i] = screen_model[i + COLUMNS];
					for (int i = moved; i < moved + COLUMNS; i++)
						screen_model[i] = {text_attr, CH_SPACE};
					cur_row--;
				end
			end
			CMD_SETPOS: begin
				cur_col = (ncol >= COLUMNS) ? COLUMNS - 1 : int'(ncol);
				cur_row = (nrow >= ROWS) ? ROWS - 1 : int'(nrow);
			end
			CMD_CLEAR: begin
				wipe_screen();
			end
			default: begin
				if (idx < CELL_COUNT)
					r.read_data = screen_model[idx];
			end
		endcase
		r.cursor_column  = 7'(cur_col);
		r.cursor_row     = 5'(cur_row);
		r.cursor_address = 12'((cur_row + 1) * COLUMNS + cur_col);
		return r;
	endfunction

	// send one command beat, optionally after a gap, and queue its result
	task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] ch, input logic [6:0] ncol,
			input logic [4:0] nrow, input logic [10:0] idx, input logic fixed,
			input result_t fixed_want);
		result_t pred;
		if (!calm && !tail_part && $urandom_range(0, 3) == 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, idx, nrow, ncol, ch};
		do @(posedge clk); while (!s_tready);
		pred = console_step(cmd, ch, ncol, nrow, idx);
		pending_results.push_back(fixed ? fixed_want : pred);
	endtask

	// one random command, weighted toward text and reads of the store
	task automatic random_cmd();
		logic [1:0]  cmd;
		logic [7:0]  ch;
		logic [6:0]  ncol;
		logic [4:0]  nrow;
		logic [10:0] idx;
		int          pick;
		ch   = 8'($urandom);
		ncol = 7'($urandom);
		nrow = 5'($urandom);
		idx  = 11'($urandom);
		pick = $urandom_range(0, 199);
		if (pick < 90) begin
			cmd = CMD_PUT;
			ch  = 8'($urandom_range(CH_SPACE, CH_TOP));
		end else if (pick < 120) begin
			cmd = CMD_PUT;
			case ($urandom_range(0, 4))
				0: ch = CH_BS;
				1: ch = CH_TAB;
				2: ch = CH_CR;
				3: ch = CH_LF;
				default: ;
			endcase
		end else if (pick < 140) begin
			cmd = CMD_SETPOS;
		end else if (pick < 197) begin
			cmd = CMD_READ;
			// half of the reads look at the cursor line
			if ($urandom_range(0, 1) == 1)
				idx = 11'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
		end else begin
			cmd = CMD_CLEAR;
		end
		send_cmd(cmd, ch, ncol, nrow, idx, 1'b0, '0);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain(input int settle);
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// attribute register write: setup then access
	task automatic write_attr(input logic [7:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ATTR_ADDR;
		pwdata  <= {24'($urandom), value};
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		text_attr = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// result side stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!calm && !tail_part && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 13) - 1;
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$error("result beat with no command outstanding: %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.cursor_column !== want.cursor_column) begin
					$error("cursor_column: expected %0d, actual %0d",
						want.cursor_column, got.cursor_column);
					fail_count++;
				end
				if (got.cursor_row !== want.cursor_row) begin
					$error("cursor_row: expected %0d, actual %0d",
						want.cursor_row, got.cursor_row);
					fail_count++;
				end
				if (got.cursor_address !== want.cursor_address) begin
					$error("cursor_address: expected %0d, actual %0d",
						want.cursor_address, got.cursor_address);
					fail_count++;
				end
				if (got.read_data !== want.read_data) begin
					$error("read_data: expected %h, actual %h",
						want.read_data, got.read_data);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		dir_row_t   dir_tbl [DIR_ROWS];
		logic [7:0] attr_value;

		// fixed expectations: '{read_data, cursor_address, cursor_row, cursor_column}
		dir_tbl = '{
			'{CMD_READ,   8'h00,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0720, 12'd80,   5'd0,  7'd0}},
			'{CMD_READ,   8'h00,  7'd0,   5'd0,  11'd2047, 1'b1, '{16'h0000, 12'd80,   5'd0,  7'd0}},
			'{CMD_PUT,    8'h41,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd81,   5'd0,  7'd1}},
			'{CMD_READ,   8'h00,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0741, 12'd81,   5'd0,  7'd1}},
			'{CMD_PUT,    CH_BS,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd80,   5'd0,  7'd0}},
			'{CMD_READ,   8'h00,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0720, 12'd80,   5'd0,  7'd0}},
			// backspace at the left margin does nothing
			'{CMD_PUT,    CH_BS,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd80,   5'd0,  7'd0}},
			'{CMD_PUT,    CH_TAB, 7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd88,   5'd0,  7'd8}},
			'{CMD_PUT,    CH_CR,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd80,   5'd0,  7'd0}},
			'{CMD_PUT,    CH_LF,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd160,  5'd1,  7'd0}},
			'{CMD_PUT,    CH_TOP, 7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd161,  5'd1,  7'd1}},
			// bytes above 0x7f and other control bytes are ignored
			'{CMD_PUT,    8'hFF,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd161,  5'd1,  7'd1}},
			'{CMD_PUT,    8'h1F,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd161,  5'd1,  7'd1}},
			'{CMD_PUT,    8'h20,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd162,  5'd1,  7'd2}},
			'{CMD_SETPOS, 8'h00,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd80,   5'd0,  7'd0}},
			// clamped to the bottom right corner
			'{CMD_SETPOS, 8'h00,  7'd127, 5'd31, 11'd0,    1'b1, '{16'h0000, 12'd2079, 5'd24, 7'd79}},
			// wrap in the status area scrolls and leaves the cursor there
			'{CMD_PUT,    8'h5A,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd2000, 5'd24, 7'd0}},
			'{CMD_READ,   8'h00,  7'd0,   5'd0,  11'd1999, 1'b1, '{16'h075A, 12'd2000, 5'd24, 7'd0}},
			'{CMD_READ,   8'h00,  7'd0,   5'd0,  11'd0,    1'b0, '0},
			'{CMD_SETPOS, 8'h00,  7'd0,   5'd22, 11'd0,    1'b1, '{16'h0000, 12'd1840, 5'd22, 7'd0}},
			// line feed on the last text row scrolls
			'{CMD_PUT,    CH_LF,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd1840, 5'd22, 7'd0}},
			'{CMD_READ,   8'h00,  7'd0,   5'd0,  11'd80,   1'b0, '0},
			'{CMD_SETPOS, 8'h00,  7'd78,  5'd0,  11'd0,    1'b1, '{16'h0000, 12'd158,  5'd0,  7'd78}},
			// tab past the last column wraps
			'{CMD_PUT,    CH_TAB, 7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd160,  5'd1,  7'd0}},
			'{CMD_CLEAR,  8'h00,  7'd0,   5'd0,  11'd0,    1'b1, '{16'h0000, 12'd80,   5'd0,  7'd0}}
		};

		wipe_screen();
		text_attr = ATTR_RESET;

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed table
		foreach (dir_tbl[i])
			send_cmd(dir_tbl[i].cmd, dir_tbl[i].ch, dir_tbl[i].ncol, dir_tbl[i].nrow,
				dir_tbl[i].idx, dir_tbl[i].fixed, dir_tbl[i].want);

		// random phases, each under its own attribute
		for (int p = 0; p < PHASES; p++) begin
			drain(SETTLE_CYCLES);
			case (p)
				0: attr_value = 8'hFF;
				1: attr_value = 8'h00;
				default: attr_value = 8'($urandom);
			endcase
			write_attr(attr_value);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				if (p == PHASES - 1 && n >= PHASE_ITEMS - TAIL_ITEMS)
					tail_part = 1'b1;
				random_cmd();
			end
		end

		drain(END_CYCLES);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### text_mode_console_writer_top.f
hdl/tmcw_pkg.sv
hdl/tmcw_ram.sv
hdl/tmcw_regs.sv
hdl/tmcw_ctrl.sv
hdl/text_mode_console_writer_top.sv
bench/testbench.sv
